// ===== rtl/gpfdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpfdp_pkg
// Shared types and constants for the GPIO pin function/data/pull port.
// ----------------------------------------------------------------------------
package gpfdp_pkg;

  localparam int NUM_BANKS = 9;

  localparam int CMD_W    = 3;
  localparam int PIN_W    = 9;
  localparam int VALUE_W  = 4;
  localparam int WORD_W   = 32;
  localparam int BANK_W   = PIN_W - 5;

  localparam int FUNC_DEPTH = NUM_BANKS * 4;
  localparam int DATA_DEPTH = NUM_BANKS;
  localparam int PULL_DEPTH = NUM_BANKS * 2;

  localparam int FUNC_AW = $clog2(FUNC_DEPTH);
  localparam int DATA_AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int PULL_AW = $clog2(PULL_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_FUNC  = 3'd0,
    CMD_GET_FUNC  = 3'd1,
    CMD_WRITE_BIT = 3'd2,
    CMD_SET_PULL  = 3'd3,
    CMD_READ_BIT  = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_MODIFY = 1'b1
  } state_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_PIN   = 1'b1;

endpackage : gpfdp_pkg
`default_nettype wire

// ===== rtl/gpio_pin_function_data_pull_port.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_pin_function_data_pull_port
// Per-pin function, output data and pull storage for a banked GPIO port.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_command, in_pin and in_value and raise start.
//   The command is taken at a rising edge where start is high and busy is
//   low. Each command produces exactly one result: out_valid pulses for one
//   cycle with out_read_value and out_status on the result ports.
//   Timing: the command edge reads the addressed words from the function,
//   data and pull memories (synchronous read). The next cycle merges the
//   field, writes the word back and registers the result, which appears in
//   the cycle after that. No new command is taken during the write-back,
//   as set by the read-then-write pass through the single-port memories.
//   busy is high during the write-back cycle only, so a following read
//   sees the update.
//   The receiver cannot stall; results must be taken when shown.
//   Reset (rst_n low, synchronous) clears the per-entry valid bits, so every
//   field reads as zero afterwards, and drops any command in progress.
// ----------------------------------------------------------------------------
module gpio_pin_function_data_pull_port (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [gpfdp_pkg::CMD_W-1:0]       in_command,
  input  wire [gpfdp_pkg::PIN_W-1:0]       in_pin,
  input  wire [gpfdp_pkg::VALUE_W-1:0]     in_value,
  output logic                             out_valid,
  output logic [gpfdp_pkg::VALUE_W-1:0]    out_read_value,
  output logic                             out_status
);
  import gpfdp_pkg::*;

  // Memories
  logic [WORD_W-1:0] func_mem [FUNC_DEPTH];
  logic [WORD_W-1:0] data_mem [DATA_DEPTH];
  logic [WORD_W-1:0] pull_mem [PULL_DEPTH];

  logic [FUNC_DEPTH-1:0] func_vld_r;
  logic [DATA_DEPTH-1:0] data_vld_r;
  logic [PULL_DEPTH-1:0] pull_vld_r;

  state_t state_r, state_nxt;

  logic                accept;
  logic [BANK_W-1:0]   in_bank;
  logic                in_ok;
  logic [FUNC_AW-1:0]  in_func_idx;
  logic [DATA_AW-1:0]  in_data_idx;
  logic [PULL_AW-1:0]  in_pull_idx;

  // Captured command
  logic [CMD_W-1:0]    cmd_r;
  logic [PIN_W-1:0]    pin_r;
  logic [VALUE_W-1:0]  value_r;
  logic                ok_r;

  logic [WORD_W-1:0]   func_rd_r, data_rd_r, pull_rd_r;
  logic                func_rv_r, data_rv_r, pull_rv_r;

  logic [FUNC_AW-1:0]  func_idx;
  logic [DATA_AW-1:0]  data_idx;
  logic [PULL_AW-1:0]  pull_idx;
  logic [4:0]          num;
  logic [WORD_W-1:0]   func_word, data_word, pull_word;
  logic [WORD_W-1:0]   func_new, data_new, pull_new;
  logic                func_we, data_we, pull_we;
  logic [VALUE_W-1:0]  rd_value;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_read_value_r;
  logic                out_status_r;

  // Address decode for the incoming command
  assign accept  = start && !busy;
  assign in_bank = in_pin[PIN_W-1:5];
  assign in_ok   = ({1'b0, in_bank} < (BANK_W+1)'(NUM_BANKS));

  always_comb begin
    logic [BANK_W+1:0] fi_full;
    logic [BANK_W:0]   pi_full;
    fi_full     = {in_bank, in_pin[4:3]};
    pi_full     = {in_bank, in_pin[4]};
    in_func_idx = fi_full[FUNC_AW-1:0];
    in_data_idx = in_bank[DATA_AW-1:0];
    in_pull_idx = pi_full[PULL_AW-1:0];
  end

  // State machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    busy          = 1'b0;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Capture the command and read the addressed words
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      pin_r   <= in_pin;
      value_r <= in_value;
      ok_r    <= in_ok;
      if (in_ok) begin
        func_rd_r <= func_mem[in_func_idx];
        data_rd_r <= data_mem[in_data_idx];
        pull_rd_r <= pull_mem[in_pull_idx];
        func_rv_r <= func_vld_r[in_func_idx];
        data_rv_r <= data_vld_r[in_data_idx];
        pull_rv_r <= pull_vld_r[in_pull_idx];
      end
    end
  end

  // Modify
  always_comb begin
    logic [BANK_W+1:0] fi_full;
    logic [BANK_W:0]   pi_full;
    num       = pin_r[4:0];
    fi_full   = {pin_r[PIN_W-1:5], num[4:3]};
    pi_full   = {pin_r[PIN_W-1:5], num[4]};
    func_idx  = fi_full[FUNC_AW-1:0];
    data_idx  = pin_r[DATA_AW+4:5];
    pull_idx  = pi_full[PULL_AW-1:0];

    // Entries never written since reset read as zero
    func_word = func_rv_r ? func_rd_r : '0;
    data_word = data_rv_r ? data_rd_r : '0;
    pull_word = pull_rv_r ? pull_rd_r : '0;

    func_new = func_word;
    func_new[{num[2:0], 2'b00} +: 4] = value_r;
    data_new = data_word;
    data_new[num] = (value_r != '0);
    pull_new = pull_word;
    pull_new[{num[3:0], 1'b0} +: 2] = value_r[1:0];

    func_we  = 1'b0;
    data_we  = 1'b0;
    pull_we  = 1'b0;
    rd_value = '0;
    if (state_r == ST_MODIFY && ok_r) begin
      case (cmd_r)
        CMD_SET_FUNC:  func_we  = 1'b1;
        CMD_GET_FUNC:  rd_value = func_word[{num[2:0], 2'b00} +: 4];
        CMD_WRITE_BIT: data_we  = 1'b1;
        CMD_SET_PULL:  pull_we  = 1'b1;
        CMD_READ_BIT:  rd_value = {{(VALUE_W-1){1'b0}}, data_word[num]};
        default:       rd_value = '0;
      endcase
    end
  end

  // Write back
  always_ff @(posedge clk) begin
    if (func_we) begin
      func_mem[func_idx] <= func_new;
    end
    if (data_we) begin
      data_mem[data_idx] <= data_new;
    end
    if (pull_we) begin
      pull_mem[pull_idx] <= pull_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_vld_r <= '0;
      data_vld_r <= '0;
      pull_vld_r <= '0;
    end else begin
      if (func_we) begin
        func_vld_r[func_idx] <= 1'b1;
      end
      if (data_we) begin
        data_vld_r[data_idx] <= 1'b1;
      end
      if (pull_we) begin
        pull_vld_r[pull_idx] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_read_value_r <= rd_value;
      out_status_r     <= ok_r ? STATUS_OK : STATUS_BAD_PIN;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted command did not enter write-back");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("write-back not followed by a single result");

  a_bad_pin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_value == '0)
    else $error("out-of-range pin returned nonzero read value");

  a_no_write_bad_pin: assert property (@(posedge clk) disable iff (!rst_n)
    (func_we || data_we || pull_we) |-> ok_r)
    else $error("memory written for out-of-range pin");
`endif

endmodule : gpio_pin_function_data_pull_port
`default_nettype wire
